// ===== hdl/pls_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pls_pkg
// shared widths and codes for the polygon line split core and its channels
// ---------------------------------------------------------------------------
package pls_pkg;

   localparam int DATA_W = 24;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CUT  = 1'b1;

   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

endpackage

// ===== hdl/pls_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pls_req_if
// request channel: vertex loads and cut lines
// ---------------------------------------------------------------------------
interface pls_req_if;
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic signed [pls_pkg::DATA_W-1:0]   first_x;
   logic signed [pls_pkg::DATA_W-1:0]   first_y;
   logic signed [pls_pkg::DATA_W-1:0]   second_x;
   logic signed [pls_pkg::DATA_W-1:0]   second_y;

   modport source (output valid, opcode, first_x, first_y, second_x, second_y,
                   input ready);
   modport sink   (input valid, opcode, first_x, first_y, second_x, second_y,
                   output ready);
endinterface

// ===== hdl/pls_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pls_rsp_if
// response channel: output polygon vertices and status
// ---------------------------------------------------------------------------
interface pls_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                side;
   logic signed [pls_pkg::DATA_W-1:0]   out_x;
   logic signed [pls_pkg::DATA_W-1:0]   out_y;
   logic                                last;
   logic                                status;

   modport source (output valid, side, out_x, out_y, last, status, input ready);
   modport sink   (input valid, side, out_x, out_y, last, status, output ready);
endinterface

// ===== hdl/polygon_line_split_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// polygon_line_split_core
// splits a stored polygon in two along a cut line, one shared multiply and
// divide datapath stepped by a sequencer
// ---------------------------------------------------------------------------
// usage:
//  - req_ch opcode load appends one vertex (ignored when the store is full);
//    a load transfer gives no response
//  - req_ch opcode cut walks edges in order, closing edge last, and stops at
//    the second crossing; every cut empties the polygon afterwards
//  - rsp_ch gives the left part then the right part (last on the final one),
//    or one failure response with status set
//  - per edge: vertex reads, then per product the low half, high half and sum
//    steps on the shared 25x26 multiplier and per quotient the bit-serial
//    divider; a general edge costs about 6 products and 2 quotients, a
//    vertical cut or edge 1 product and 1 quotient, a miss less
//  - a vertex response is read from the store, then set in the output register
//  - req_ch.ready is high only while idle; a cut is fully drained before the
//    next request transfer
//  - a stalled rsp_ch holds the output register and the sequencer waits
//  - reset empties the polygon and idles the sequencer; vertex store
//    contents are not cleared
// ---------------------------------------------------------------------------
module polygon_line_split_core #(
   parameter int MAX_VERTICES = 16
) (
   input logic      clock,
   input logic      reset,
   pls_req_if.sink  req_ch,
   pls_rsp_if.source rsp_ch
);

   localparam int DW   = pls_pkg::DATA_W;
   localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW   = $clog2(MAX_VERTICES + 1);
   localparam int DIFW = DW + 2;       // coordinate differences
   localparam int AMW  = DW + 1;       // difference magnitude
   localparam int BW   = 52;           // second operand, den and num
   localparam int HW   = BW / 2;       // multiplier chunk
   localparam int PRW  = AMW + HW;     // one partial product
   localparam int PW   = AMW + BW;     // full product magnitude
   localparam int RW   = BW + 1;       // divider remainder
   localparam int QW   = DW + 3;       // quotient, saturating
   localparam int SW   = QW + 2;       // base plus quotient
   localparam int NW   = $clog2(PW + 1);

   localparam logic signed [SW-1:0] SAT_HI = SW'(2 ** (DW - 1) - 1);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_W, ST_EVAL,
      ST_MUL_LO, ST_MUL_HI, ST_MUL_SUM, ST_POST, ST_DIV_RUN, ST_DIV_END,
      ST_CHECK, ST_ACCEPT, ST_NEXT, ST_EM_SEL, ST_EM_RD, ST_EM_WAIT
   } state_type;

   typedef enum logic [2:0] {
      PH_DEN1, PH_DEN2, PH_NUM1, PH_NUM2, PH_X, PH_Y, PH_VY
   } phase_type;

   typedef enum logic [2:0] {
      SEG_L1, SEG_C0L, SEG_C1L, SEG_L2, SEG_C1R, SEG_C0R, SEG_R
   } seg_type;

   function automatic logic between(input logic signed [DW-1:0] v,
                                    input logic signed [DW-1:0] a,
                                    input logic signed [DW-1:0] b);
      return (v > a && v < b) || (v < a && v > b);
   endfunction

   function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = v;
      if (v > SAT_HI) r = SAT_HI;
      if (v < SAT_LO) r = SAT_LO;
      return r[DW-1:0];
   endfunction

   // vertex store
   logic signed [DW-1:0] vx_mem [MAX_VERTICES];
   logic signed [DW-1:0] vy_mem [MAX_VERTICES];
   logic signed [DW-1:0] rdx_ff, rdy_ff;
   logic [AW-1:0]        raddr;
   logic                 mem_we;

   state_type state_ff;
   phase_type phase_ff;
   seg_type   seg_ff;

   logic [CW-1:0] count_ff, n_ff, v_ff;
   logic [AW-1:0] e_ff, idx0_ff, idx1_ff, nx;
   logic          found_ff;

   logic signed [DW-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [DW-1:0] px_ff, py_ff, c0x_ff, c0y_ff, c1x_ff, c1y_ff;

   // vertical case operands
   logic signed [DIFW-1:0] va_ff, vb_ff, vd_ff;
   logic signed [DW-1:0]   vbase_ff;

   // products and quotients
   logic [PRW-1:0]        prod_ff;
   logic [PW-1:0]         pmag_ff;
   logic                  pneg_ff;
   logic signed [BW-1:0]  t1_ff, den_ff, num_ff;
   logic [PW-1:0]         dvd_ff;
   logic [RW-1:0]         rem_ff;
   logic [BW-1:0]         dmag_ff;
   logic [QW-1:0]         q_ff;
   logic                  big_ff, qneg_ff;
   logic [NW-1:0]         dcnt_ff;

   // output register
   logic                 out_valid_ff, out_side_ff, out_last_ff, out_status_ff;
   logic signed [DW-1:0] out_x_ff, out_y_ff;

   // cut and edge differences
   logic signed [DIFW-1:0] dx1, dy1, dx2, dy2, bxe, bye, exb, axe;
   assign dx1 = DIFW'(sx_ff) - DIFW'(ex_ff);
   assign dy1 = DIFW'(sy_ff) - DIFW'(ey_ff);
   assign dx2 = DIFW'(ax_ff) - DIFW'(bx_ff);
   assign dy2 = DIFW'(ay_ff) - DIFW'(by_ff);
   assign bxe = DIFW'(bx_ff) - DIFW'(ex_ff);
   assign bye = DIFW'(by_ff) - DIFW'(ey_ff);
   assign exb = DIFW'(ex_ff) - DIFW'(bx_ff);
   assign axe = DIFW'(ax_ff) - DIFW'(ex_ff);

   // shared multiplier operand select
   logic signed [DIFW-1:0] mul_a;
   logic signed [BW-1:0]   mul_b, div_d;
   logic signed [DW-1:0]   div_base;
   always_comb begin
      mul_a    = dx1;
      mul_b    = BW'(dy2);
      div_d    = den_ff;
      div_base = ex_ff;
      case (phase_ff)
         PH_DEN1: begin mul_a = dx1; mul_b = BW'(dy2); end
         PH_DEN2: begin mul_a = dy1; mul_b = BW'(dx2); end
         PH_NUM1: begin mul_a = bxe; mul_b = BW'(dy2); end
         PH_NUM2: begin mul_a = bye; mul_b = BW'(dx2); end
         PH_X: begin
            mul_a = dx1; mul_b = num_ff; div_base = ex_ff;
         end
         PH_Y: begin
            mul_a = dy1; mul_b = num_ff; div_base = ey_ff;
         end
         PH_VY: begin
            mul_a = va_ff; mul_b = BW'(vb_ff); div_d = BW'(vd_ff);
            div_base = vbase_ff;
         end
         default: begin mul_a = dx1; mul_b = BW'(dy2); end
      endcase
   end

   logic               a_neg, b_neg, d_neg;
   logic [DIFW-1:0]    a_abs;
   logic [AMW-1:0]     a_mag;
   logic [BW-1:0]      b_mag, d_mag;
   assign a_neg = mul_a[DIFW-1];
   assign b_neg = mul_b[BW-1];
   assign d_neg = div_d[BW-1];
   assign a_abs = a_neg ? DIFW'(-mul_a) : DIFW'(mul_a);
   assign a_mag = a_abs[AMW-1:0];
   assign b_mag = b_neg ? BW'(-mul_b) : BW'(mul_b);
   assign d_mag = d_neg ? BW'(-div_d) : BW'(div_d);

   // signed view of a small product
   logic signed [BW-1:0] p_low, p_signed;
   assign p_low    = pmag_ff[BW-1:0];
   assign p_signed = pneg_ff ? -p_low : p_low;

   // one restoring divide step
   logic [RW-1:0] r2;
   logic          ge;
   assign r2 = {rem_ff[RW-2:0], dvd_ff[PW-1]};
   assign ge = (r2 >= RW'(dmag_ff));

   // saturated coordinate from base and quotient
   logic [QW-1:0]         q_use;
   logic signed [SW-1:0]  q_s, sum_s;
   logic signed [DW-1:0]  res;
   assign q_use = big_ff ? {1'b1, {(QW-1){1'b0}}} : q_ff;
   assign q_s   = SW'(q_use);
   assign sum_s = SW'(div_base) + (qneg_ff ? -q_s : q_s);
   assign res   = sat_dw(sum_s);

   assign nx = (CW'(e_ff) + CW'(1) == n_ff) ? '0 : AW'(e_ff + AW'(1));

   always_comb begin
      case (state_ff)
         ST_RD_A:   raddr = e_ff;
         ST_RD_B:   raddr = nx;
         ST_EM_SEL: raddr = v_ff[AW-1:0];
         default:   raddr = e_ff;
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign mem_we = req_ch.valid && req_ch.ready && req_ch.opcode == pls_pkg::OP_LOAD
                   && count_ff < CW'(MAX_VERTICES);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vx_mem[count_ff[AW-1:0]] <= req_ch.first_x;
         vy_mem[count_ff[AW-1:0]] <= req_ch.first_y;
      end
      rdx_ff <= vx_mem[raddr];
      rdy_ff <= vy_mem[raddr];
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.side   = out_side_ff;
   assign rsp_ch.out_x  = out_x_ff;
   assign rsp_ch.out_y  = out_y_ff;
   assign rsp_ch.last   = out_last_ff;
   assign rsp_ch.status = out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  if (req_ch.opcode == pls_pkg::OP_LOAD) begin
                     if (mem_we) count_ff <= count_ff + CW'(1);
                  end else begin
                     sx_ff    <= req_ch.first_x;
                     sy_ff    <= req_ch.first_y;
                     ex_ff    <= req_ch.second_x;
                     ey_ff    <= req_ch.second_y;
                     n_ff     <= count_ff;
                     count_ff <= '0;
                     e_ff     <= '0;
                     found_ff <= 1'b0;
                     if (count_ff < CW'(3)) begin
                        // too few vertices: straight to failure
                        out_valid_ff  <= 1'b1;
                        out_side_ff   <= pls_pkg::SIDE_LEFT;
                        out_x_ff      <= '0;
                        out_y_ff      <= '0;
                        out_last_ff   <= 1'b1;
                        out_status_ff <= pls_pkg::STATUS_FAIL;
                        state_ff      <= ST_EM_WAIT;
                     end else begin
                        state_ff <= ST_RD_A;
                     end
                  end
               end
            end
            ST_RD_A: state_ff <= ST_RD_B;
            ST_RD_B: begin
               ax_ff    <= rdx_ff;
               ay_ff    <= rdy_ff;
               state_ff <= ST_RD_W;
            end
            ST_RD_W: begin
               bx_ff    <= rdx_ff;
               by_ff    <= rdy_ff;
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (sx_ff == ex_ff) begin
                  // vertical cut
                  if (ax_ff == bx_ff || !between(ex_ff, ax_ff, bx_ff)) begin
                     state_ff <= ST_NEXT;
                  end else begin
                     px_ff    <= ex_ff;
                     va_ff    <= exb;
                     vb_ff    <= dy2;
                     vd_ff    <= dx2;
                     vbase_ff <= by_ff;
                     phase_ff <= PH_VY;
                     state_ff <= ST_MUL_LO;
                  end
               end else if (ax_ff == bx_ff) begin
                  // vertical edge
                  if (!between(ax_ff, sx_ff, ex_ff)) begin
                     state_ff <= ST_NEXT;
                  end else begin
                     px_ff    <= ax_ff;
                     va_ff    <= axe;
                     vb_ff    <= dy1;
                     vd_ff    <= dx1;
                     vbase_ff <= ey_ff;
                     phase_ff <= PH_VY;
                     state_ff <= ST_MUL_LO;
                  end
               end else begin
                  phase_ff <= PH_DEN1;
                  state_ff <= ST_MUL_LO;
               end
            end
            ST_MUL_LO: begin
               prod_ff  <= a_mag * b_mag[HW-1:0];
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               pmag_ff  <= PW'(prod_ff);
               prod_ff  <= a_mag * b_mag[BW-1:HW];
               state_ff <= ST_MUL_SUM;
            end
            ST_MUL_SUM: begin
               pmag_ff  <= pmag_ff + (PW'(prod_ff) << HW);
               pneg_ff  <= a_neg ^ b_neg;
               state_ff <= ST_POST;
            end
            ST_POST: begin
               case (phase_ff)
                  PH_DEN1: begin
                     t1_ff    <= p_signed;
                     phase_ff <= PH_DEN2;
                     state_ff <= ST_MUL_LO;
                  end
                  PH_DEN2: begin
                     den_ff <= t1_ff - p_signed;
                     if (t1_ff == p_signed) begin
                        // parallel
                        state_ff <= ST_NEXT;
                     end else begin
                        phase_ff <= PH_NUM1;
                        state_ff <= ST_MUL_LO;
                     end
                  end
                  PH_NUM1: begin
                     t1_ff    <= p_signed;
                     phase_ff <= PH_NUM2;
                     state_ff <= ST_MUL_LO;
                  end
                  PH_NUM2: begin
                     num_ff   <= t1_ff - p_signed;
                     phase_ff <= PH_X;
                     state_ff <= ST_MUL_LO;
                  end
                  default: begin
                     // start the divide
                     dvd_ff   <= pmag_ff;
                     rem_ff   <= '0;
                     dmag_ff  <= d_mag;
                     qneg_ff  <= pneg_ff ^ d_neg;
                     q_ff     <= '0;
                     big_ff   <= 1'b0;
                     dcnt_ff  <= NW'(PW);
                     state_ff <= ST_DIV_RUN;
                  end
               endcase
            end
            ST_DIV_RUN: begin
               rem_ff <= ge ? r2 - RW'(dmag_ff) : r2;
               dvd_ff <= dvd_ff << 1;
               if (q_ff[QW-1]) big_ff <= 1'b1;
               else q_ff <= {q_ff[QW-2:0], ge};
               dcnt_ff <= dcnt_ff - NW'(1);
               if (dcnt_ff == NW'(1)) state_ff <= ST_DIV_END;
            end
            ST_DIV_END: begin
               case (phase_ff)
                  PH_X: begin
                     px_ff    <= res;
                     phase_ff <= PH_Y;
                     state_ff <= ST_MUL_LO;
                  end
                  PH_Y: begin
                     py_ff    <= res;
                     state_ff <= ST_CHECK;
                  end
                  default: begin
                     py_ff    <= res;
                     state_ff <= ST_ACCEPT;
                  end
               endcase
            end
            ST_CHECK: begin
               if (between(px_ff, ax_ff, bx_ff) &&
                   (dy1 == '0 || dy2 == '0 || between(py_ff, ay_ff, by_ff)))
                  state_ff <= ST_ACCEPT;
               else
                  state_ff <= ST_NEXT;
            end
            ST_ACCEPT: begin
               if (!found_ff) begin
                  c0x_ff   <= px_ff;
                  c0y_ff   <= py_ff;
                  idx0_ff  <= e_ff;
                  found_ff <= 1'b1;
                  state_ff <= ST_NEXT;
               end else begin
                  c1x_ff   <= px_ff;
                  c1y_ff   <= py_ff;
                  idx1_ff  <= e_ff;
                  seg_ff   <= SEG_L1;
                  v_ff     <= '0;
                  state_ff <= ST_EM_SEL;
               end
            end
            ST_NEXT: begin
               if (CW'(e_ff) + CW'(1) == n_ff) begin
                  // fewer than two crossings
                  out_valid_ff  <= 1'b1;
                  out_side_ff   <= pls_pkg::SIDE_LEFT;
                  out_x_ff      <= '0;
                  out_y_ff      <= '0;
                  out_last_ff   <= 1'b1;
                  out_status_ff <= pls_pkg::STATUS_FAIL;
                  state_ff      <= ST_EM_WAIT;
               end else begin
                  e_ff     <= e_ff + AW'(1);
                  state_ff <= ST_RD_A;
               end
            end
            ST_EM_SEL: begin
               out_last_ff   <= 1'b0;
               out_status_ff <= pls_pkg::STATUS_OK;
               case (seg_ff)
                  SEG_C0L, SEG_C1L, SEG_C1R, SEG_C0R: begin
                     out_valid_ff <= 1'b1;
                     out_side_ff  <= (seg_ff inside {SEG_C1R, SEG_C0R}) ?
                                     pls_pkg::SIDE_RIGHT : pls_pkg::SIDE_LEFT;
                     out_x_ff     <= (seg_ff inside {SEG_C0L, SEG_C0R}) ?
                                     c0x_ff : c1x_ff;
                     out_y_ff     <= (seg_ff inside {SEG_C0L, SEG_C0R}) ?
                                     c0y_ff : c1y_ff;
                     state_ff     <= ST_EM_WAIT;
                  end
                  default: begin
                     // empty tail of the left part
                     if (seg_ff == SEG_L2 && v_ff == n_ff) seg_ff <= SEG_C1R;
                     else state_ff <= ST_EM_RD;
                  end
               endcase
            end
            ST_EM_RD: begin
               out_valid_ff <= 1'b1;
               out_side_ff  <= (seg_ff == SEG_R) ? pls_pkg::SIDE_RIGHT
                                                 : pls_pkg::SIDE_LEFT;
               out_x_ff     <= rdx_ff;
               out_y_ff     <= rdy_ff;
               out_last_ff  <= (seg_ff == SEG_R) && (v_ff == CW'(idx1_ff));
               state_ff     <= ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
               if (rsp_ch.ready) begin
                  out_valid_ff <= 1'b0;
                  if (out_last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_EM_SEL;
                     case (seg_ff)
                        SEG_L1: begin
                           if (v_ff == CW'(idx0_ff)) seg_ff <= SEG_C0L;
                           else v_ff <= v_ff + CW'(1);
                        end
                        SEG_C0L: seg_ff <= SEG_C1L;
                        SEG_C1L: begin
                           seg_ff <= SEG_L2;
                           v_ff   <= CW'(idx1_ff) + CW'(1);
                        end
                        SEG_L2: begin
                           if (v_ff + CW'(1) == n_ff) seg_ff <= SEG_C1R;
                           else v_ff <= v_ff + CW'(1);
                        end
                        SEG_C1R: seg_ff <= SEG_C0R;
                        SEG_C0R: begin
                           seg_ff <= SEG_R;
                           v_ff   <= CW'(idx0_ff) + CW'(1);
                        end
                        default: v_ff <= v_ff + CW'(1);
                     endcase
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
